FILE: rtl/osss_pkg.sv
`default_nettype none

package osss_pkg;

  localparam int INPUT_WIDTH  = 8;
  localparam int OSCILLATORS  = 8;
  localparam int OUTPUT_WIDTH = 8;
  localparam int STATE_SIZE   = 2 * OSCILLATORS;

  localparam int IN_AW  = $clog2(INPUT_WIDTH);
  localparam int OSC_AW = $clog2(OSCILLATORS);
  localparam int OUT_AW = $clog2(OUTPUT_WIDTH);
  localparam int ST_AW  = $clog2(STATE_SIZE);
  localparam int IDX_W  = (ST_AW > IN_AW) ? ST_AW : IN_AW;
  localparam int BW_AW  = IN_AW + ST_AW;
  localparam int CW_AW  = ST_AW + OUT_AW;
  localparam int BW_DEPTH = INPUT_WIDTH * STATE_SIZE;
  localparam int CW_DEPTH = STATE_SIZE * OUTPUT_WIDTH;

  localparam int MW     = 26;
  localparam int ACC_W  = 64;
  localparam int DIV_NW = 60;
  localparam int DIV_DW = 38;
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 16;

  localparam logic [3:0] PROG_LAST_MID  = 4'd13;
  localparam logic [3:0] PROG_LAST_HEUN = 4'd11;

  typedef enum logic [2:0] {
    ACT_IN_W   = 3'd0,
    ACT_OUT_W  = 3'd1,
    ACT_DAMP   = 3'd2,
    ACT_FREQ   = 3'd3,
    ACT_BIAS   = 3'd4,
    ACT_SAMPLE = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MODE = 1'b0,
    CFG_STEP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t            action;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] word_value;
    logic               step_last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [3:0]         out_channel;
    logic               out_last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PRJ_RD, S_PRJ_MAC, S_PRJ_END, S_LDX0, S_LDX1, S_SOLVE, S_WB,
    S_DIV0, S_DIVW0, S_DIV1, S_DIVW1, S_WRX0, S_WRX1,
    S_OUT_BIAS, S_OUT_RD, S_OUT_MAC, S_OUT_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OPS_DT, OPS_LAM, OPS_OM, OPS_X0, OPS_X1, OPS_U0, OPS_U1, OPS_A,
    OPS_N, OPS_DW, OPS_R0, OPS_R1, OPS_XH0, OPS_XH1, OPS_KS0, OPS_KS1
  } operand_t;

  typedef enum logic [3:0] {
    D_DL, D_DW, D_R0, D_R1, D_DET, D_NUM0, D_NUM1, D_DU0, D_DU1,
    D_AX0, D_AX1, D_AH0, D_AH1, D_N0, D_N1
  } dest_t;

  typedef struct packed {
    operand_t sa;
    operand_t sb;
    logic     neg;
    logic     first;
    logic     last;
    dest_t    dst;
  } mop_t;

  function automatic mop_t mk(operand_t sa, operand_t sb, logic neg, logic first,
                              logic last, dest_t dst);
    mop_t m;
    m.sa = sa;
    m.sb = sb;
    m.neg = neg;
    m.first = first;
    m.last = last;
    m.dst = dst;
    return m;
  endfunction

  function automatic mop_t prog(logic mode, logic [3:0] pc);
    mop_t m;
    m = mk(OPS_DT, OPS_DT, 1'b0, 1'b1, 1'b0, D_DL);
    if (!mode) begin
      case (pc)
        4'd0:  m = mk(OPS_DT, OPS_LAM, 1'b0, 1'b1, 1'b1, D_DL);
        4'd1:  m = mk(OPS_DT, OPS_OM,  1'b0, 1'b1, 1'b1, D_DW);
        4'd2:  m = mk(OPS_N,  OPS_X0,  1'b0, 1'b1, 1'b0, D_R0);
        4'd3:  m = mk(OPS_DW, OPS_X1,  1'b0, 1'b0, 1'b0, D_R0);
        4'd4:  m = mk(OPS_DT, OPS_U0,  1'b0, 1'b0, 1'b1, D_R0);
        4'd5:  m = mk(OPS_DW, OPS_X0,  1'b1, 1'b1, 1'b0, D_R1);
        4'd6:  m = mk(OPS_N,  OPS_X1,  1'b0, 1'b0, 1'b0, D_R1);
        4'd7:  m = mk(OPS_DT, OPS_U1,  1'b0, 1'b0, 1'b1, D_R1);
        4'd8:  m = mk(OPS_A,  OPS_A,   1'b0, 1'b1, 1'b0, D_DET);
        4'd9:  m = mk(OPS_DW, OPS_DW,  1'b0, 1'b0, 1'b1, D_DET);
        4'd10: m = mk(OPS_A,  OPS_R0,  1'b0, 1'b1, 1'b0, D_NUM0);
        4'd11: m = mk(OPS_DW, OPS_R1,  1'b0, 1'b0, 1'b1, D_NUM0);
        4'd12: m = mk(OPS_DW, OPS_R0,  1'b1, 1'b1, 1'b0, D_NUM1);
        4'd13: m = mk(OPS_A,  OPS_R1,  1'b0, 1'b0, 1'b1, D_NUM1);
        default: m = mk(OPS_DT, OPS_DT, 1'b0, 1'b1, 1'b0, D_DL);
      endcase
    end else begin
      case (pc)
        4'd0:  m = mk(OPS_DT,  OPS_U0,  1'b0, 1'b1, 1'b1, D_DU0);
        4'd1:  m = mk(OPS_DT,  OPS_U1,  1'b0, 1'b1, 1'b1, D_DU1);
        4'd2:  m = mk(OPS_LAM, OPS_X0,  1'b1, 1'b1, 1'b0, D_AX0);
        4'd3:  m = mk(OPS_OM,  OPS_X1,  1'b0, 1'b0, 1'b1, D_AX0);
        4'd4:  m = mk(OPS_OM,  OPS_X0,  1'b1, 1'b1, 1'b0, D_AX1);
        4'd5:  m = mk(OPS_LAM, OPS_X1,  1'b1, 1'b0, 1'b1, D_AX1);
        4'd6:  m = mk(OPS_LAM, OPS_XH0, 1'b1, 1'b1, 1'b0, D_AH0);
        4'd7:  m = mk(OPS_OM,  OPS_XH1, 1'b0, 1'b0, 1'b1, D_AH0);
        4'd8:  m = mk(OPS_OM,  OPS_XH0, 1'b1, 1'b1, 1'b0, D_AH1);
        4'd9:  m = mk(OPS_LAM, OPS_XH1, 1'b1, 1'b0, 1'b1, D_AH1);
        4'd10: m = mk(OPS_DT,  OPS_KS0, 1'b0, 1'b1, 1'b1, D_N0);
        4'd11: m = mk(OPS_DT,  OPS_KS1, 1'b0, 1'b1, 1'b1, D_N1);
        default: m = mk(OPS_DT, OPS_DT, 1'b0, 1'b1, 1'b0, D_DL);
      endcase
    end
    return m;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                  input int unsigned n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = 24'sh7FFFFF;
    else if (v < -64'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [23:0] addsat24(input logic signed [23:0] a,
                                                  input logic signed [23:0] b);
    return sat24(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [23:0] qsat(input logic neg, input logic [DIV_NW-1:0] q);
    logic signed [23:0] r;
    if (q >= 60'd8388608) r = neg ? 24'sh800000 : 24'sh7FFFFF;
    else if (neg) r = -$signed(q[23:0]);
    else r = q[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/osss_mac.sv
`default_nettype none

module osss_mac import osss_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic                    first,
  input  wire logic                    neg,
  input  wire logic signed [MW-1:0]    a,
  input  wire logic signed [MW-1:0]    b,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [2*MW-1:0]  prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  assign prod    = a * b;
  assign term    = neg ? -ACC_W'(prod) : ACC_W'(prod);
  assign acc_nxt = (first ? '0 : acc_r) + term;
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/osss_div.sv
`default_nettype none

module osss_div import osss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [DIV_NW-1:0]      quotient
);

  localparam int CW = $clog2(DIV_NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DIV_DW:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0] trial;
  logic [DIV_DW:0] rem_nxt;
  logic            qbit;

  assign trial = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign rem_nxt = qbit ? (trial - {1'b0, divisor}) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NW-2:0], qbit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/oscillator_state_space_scan.sv
// Damped-oscillator state-space layer, one inference layer over a sequence.
// Input items arrive on in_valid/in_ready/in_data. Weight, table and sample
// items are stored when accepted. The sample item that carries step_last
// starts a time step; in_ready stays low until the step is done.
// A time step projects the sample into each oscillator pair, advances the
// pair and then forms eight output items, one per channel, with out_last set
// on the final channel. All products go through one shared multiply-
// accumulate unit; the midpoint update also uses one shared bit-serial
// divider for its two quotients per pair.
// Each step reads 128 projection and 128 output products from the weight
// memories, adds one bias product per channel and runs, per pair, the
// update program and, in midpoint mode, the divider for each quotient.
// Output items leave through an output register; when the receiver stalls,
// the step waits at its next item, and the block takes new input as soon as
// its last item sits in that register.
// Reset, synchronous and active low, clears the oscillator state and sets
// midpoint mode, step size one. Configuration writes on cfg_wr_en take
// effect at once; the user must make them while the block idles, unchecked.
`default_nettype none

module oscillator_state_space_scan import osss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [OSC_AW-1:0] k_r, k_nxt;
  logic              h_r, h_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [OUT_AW-1:0] j_r, j_nxt;
  logic [3:0]        pc_r, pc_nxt;
  logic              wb_en_r;
  dest_t             wb_dst_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              mode_r;
  logic [15:0]       step_r;

  logic signed [15:0] bw_mem [BW_DEPTH];
  logic signed [15:0] cw_mem [CW_DEPTH];
  logic signed [15:0] bw_rd_r, cw_rd_r;
  logic signed [15:0] damp_r [OSCILLATORS];
  logic signed [15:0] freq_r [OSCILLATORS];
  logic signed [15:0] bias_r [OUTPUT_WIDTH];
  logic signed [15:0] samp_r [INPUT_WIDTH];
  logic signed [23:0] x_r [STATE_SIZE];

  logic signed [23:0] u0_r, u1_r, x0_r, x1_r, r0_r, r1_r;
  logic signed [20:0] a_r, n_r, dw_r;
  logic [DIV_DW-1:0]  det_r;
  logic signed [ACC_W-1:0] num0_r, num1_r;
  logic signed [23:0] du0_r, du1_r, k10_r, k11_r, k20_r, k21_r, n0_r, n1_r;

  logic in_fire, emit, prog_end;
  logic bw_we, cw_we;
  logic [BW_AW-1:0] bw_waddr, bw_raddr;
  logic [CW_AW-1:0] cw_waddr, cw_raddr;
  logic [ST_AW-1:0] xaddr;
  logic signed [23:0] xrd, xh0, xh1;
  logic signed [24:0] ks0, ks1;
  logic signed [15:0] lam, om, samp, bias;
  mop_t mop;

  logic mac_en, mac_first, mac_neg;
  logic signed [MW-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] acc;

  logic div_start, div_busy, div_done;
  logic signed [ACC_W-1:0] num_sel, num_abs;
  logic [DIV_NW-1:0] dividend, quo;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit     = (state_r == S_OUT_EMIT) && (!out_valid_r || out_ready);
  assign mop      = prog(mode_r, pc_r);
  assign prog_end = mode_r ? (pc_r == PROG_LAST_HEUN) : (pc_r == PROG_LAST_MID);

  assign lam  = damp_r[k_r];
  assign om   = freq_r[k_r];
  assign samp = samp_r[i_r[IN_AW-1:0]];
  assign bias = bias_r[j_r];

  assign xaddr = (state_r == S_LDX0) ? {k_r, 1'b0} :
                 (state_r == S_LDX1) ? {k_r, 1'b1} : i_r[ST_AW-1:0];
  assign xrd   = x_r[xaddr];
  assign xh0   = addsat24(x0_r, k10_r);
  assign xh1   = addsat24(x1_r, k11_r);
  assign ks0   = 25'(k10_r) + 25'(k20_r);
  assign ks1   = 25'(k11_r) + 25'(k21_r);

  assign bw_raddr = {i_r[IN_AW-1:0], k_r, h_r};
  assign cw_raddr = {i_r[ST_AW-1:0], j_r};
  assign bw_waddr = {in_data.row_index[IN_AW-1:0], in_data.col_index[ST_AW-1:0]};
  assign cw_waddr = {in_data.row_index[ST_AW-1:0], in_data.col_index[OUT_AW-1:0]};
  assign bw_we = in_fire && (in_data.action == ACT_IN_W) &&
                 (int'(in_data.row_index) < INPUT_WIDTH) &&
                 (int'(in_data.col_index) < STATE_SIZE);
  assign cw_we = in_fire && (in_data.action == ACT_OUT_W) &&
                 (int'(in_data.row_index) < STATE_SIZE) &&
                 (int'(in_data.col_index) < OUTPUT_WIDTH);

  function automatic logic signed [MW-1:0] pick(operand_t s);
    logic signed [MW-1:0] v;
    case (s)
      OPS_DT:  v = MW'(signed'({1'b0, step_r}));
      OPS_LAM: v = MW'(lam);
      OPS_OM:  v = MW'(om);
      OPS_X0:  v = MW'(x0_r);
      OPS_X1:  v = MW'(x1_r);
      OPS_U0:  v = MW'(u0_r);
      OPS_U1:  v = MW'(u1_r);
      OPS_A:   v = MW'(a_r);
      OPS_N:   v = MW'(n_r);
      OPS_DW:  v = MW'(dw_r);
      OPS_R0:  v = MW'(r0_r);
      OPS_R1:  v = MW'(r1_r);
      OPS_XH0: v = MW'(xh0);
      OPS_XH1: v = MW'(xh1);
      OPS_KS0: v = MW'(ks0);
      OPS_KS1: v = MW'(ks1);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    h_nxt = h_r;
    i_nxt = i_r;
    j_nxt = j_r;
    pc_nxt = pc_r;
    mac_en = 1'b0;
    mac_first = 1'b0;
    mac_neg = 1'b0;
    mac_a = pick(mop.sa);
    mac_b = pick(mop.sb);
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.action == ACT_SAMPLE) && in_data.step_last) begin
          state_nxt = S_PRJ_RD;
          k_nxt = '0;
          h_nxt = 1'b0;
          i_nxt = '0;
        end
      end
      S_PRJ_RD: state_nxt = S_PRJ_MAC;
      S_PRJ_MAC: begin
        mac_en = 1'b1;
        mac_first = (i_r == '0);
        mac_a = MW'(bw_rd_r);
        mac_b = MW'(samp);
        if (i_r == IDX_W'(INPUT_WIDTH - 1)) begin
          state_nxt = S_PRJ_END;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_PRJ_RD;
        end
      end
      S_PRJ_END: begin
        i_nxt = '0;
        if (!h_r) begin
          h_nxt = 1'b1;
          state_nxt = S_PRJ_RD;
        end else begin
          h_nxt = 1'b0;
          state_nxt = S_LDX0;
        end
      end
      S_LDX0: state_nxt = S_LDX1;
      S_LDX1: begin
        pc_nxt = '0;
        state_nxt = S_SOLVE;
      end
      S_SOLVE: begin
        mac_en = 1'b1;
        mac_first = mop.first;
        mac_neg = mop.neg;
        if (prog_end) begin
          state_nxt = S_WB;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_WB: state_nxt = mode_r ? S_WRX0 : S_DIV0;
      S_DIV0: begin
        div_start = 1'b1;
        state_nxt = S_DIVW0;
      end
      S_DIVW0: if (div_done) state_nxt = S_DIV1;
      S_DIV1: begin
        div_start = 1'b1;
        state_nxt = S_DIVW1;
      end
      S_DIVW1: if (div_done) state_nxt = S_WRX0;
      S_WRX0: state_nxt = S_WRX1;
      S_WRX1: begin
        if (k_r == OSC_AW'(OSCILLATORS - 1)) begin
          j_nxt = '0;
          state_nxt = S_OUT_BIAS;
        end else begin
          k_nxt = k_r + 1'b1;
          i_nxt = '0;
          h_nxt = 1'b0;
          state_nxt = S_PRJ_RD;
        end
      end
      S_OUT_BIAS: begin
        mac_en = 1'b1;
        mac_first = 1'b1;
        mac_a = MW'(bias);
        mac_b = MW'(32'sd65536);
        i_nxt = '0;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: state_nxt = S_OUT_MAC;
      S_OUT_MAC: begin
        mac_en = 1'b1;
        mac_a = MW'(cw_rd_r);
        mac_b = MW'(xrd);
        if (i_r == IDX_W'(STATE_SIZE - 1)) begin
          state_nxt = S_OUT_EMIT;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_EMIT: begin
        if (emit) begin
          if (j_r == OUT_AW'(OUTPUT_WIDTH - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_OUT_BIAS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
      h_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      pc_r <= '0;
      wb_en_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r <= 1'b0;
      step_r <= 16'd4096;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      h_r <= h_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      pc_r <= pc_nxt;
      wb_en_r <= (state_r == S_SOLVE) && mop.last;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MODE) mode_r <= cfg_data[0];
        else if (cfg_index == CFG_STEP) step_r <= cfg_data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < STATE_SIZE; e++) x_r[e] <= '0;
    end else if (in_fire && (in_data.action == ACT_CLEAR)) begin
      for (int e = 0; e < STATE_SIZE; e++) x_r[e] <= '0;
    end else if (state_r == S_WRX0) begin
      x_r[{k_r, 1'b0}] <= n0_r;
    end else if (state_r == S_WRX1) begin
      x_r[{k_r, 1'b1}] <= n1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bw_we) bw_mem[bw_waddr] <= in_data.word_value;
    bw_rd_r <= bw_mem[bw_raddr];
  end

  always_ff @(posedge clk) begin
    if (cw_we) cw_mem[cw_waddr] <= in_data.word_value;
    cw_rd_r <= cw_mem[cw_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (in_data.action)
        ACT_DAMP: if (int'(in_data.row_index) < OSCILLATORS)
          damp_r[in_data.row_index[OSC_AW-1:0]] <= in_data.word_value;
        ACT_FREQ: if (int'(in_data.row_index) < OSCILLATORS)
          freq_r[in_data.row_index[OSC_AW-1:0]] <= in_data.word_value;
        ACT_BIAS: if (int'(in_data.row_index) < OUTPUT_WIDTH)
          bias_r[in_data.row_index[OUT_AW-1:0]] <= in_data.word_value;
        ACT_SAMPLE: if (int'(in_data.row_index) < INPUT_WIDTH)
          samp_r[in_data.row_index[IN_AW-1:0]] <= in_data.word_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wb_dst_r <= mop.dst;
    if (state_r == S_PRJ_END) begin
      if (!h_r) u0_r <= sat24(rnd(acc, 8));
      else u1_r <= sat24(rnd(acc, 8));
    end
    if (state_r == S_LDX0) x0_r <= xrd;
    if (state_r == S_LDX1) x1_r <= xrd;
    if (wb_en_r) begin
      case (wb_dst_r)
        D_DL: begin
          a_r <= 21'(64'sd4096 + rnd(acc, 13));
          n_r <= 21'(64'sd4096 - rnd(acc, 13));
        end
        D_DW:   dw_r <= 21'(rnd(acc, 13));
        D_R0:   r0_r <= sat24(rnd(acc, 12));
        D_R1:   r1_r <= sat24(rnd(acc, 12));
        D_DET:  det_r <= acc[DIV_DW-1:0];
        D_NUM0: num0_r <= acc <<< 12;
        D_NUM1: num1_r <= acc <<< 12;
        D_DU0:  du0_r <= sat24(rnd(acc, 12));
        D_DU1:  du1_r <= sat24(rnd(acc, 12));
        D_AX0:  k10_r <= addsat24(sat24(rnd(acc, 12)), du0_r);
        D_AX1:  k11_r <= addsat24(sat24(rnd(acc, 12)), du1_r);
        D_AH0:  k20_r <= addsat24(sat24(rnd(acc, 12)), du0_r);
        D_AH1:  k21_r <= addsat24(sat24(rnd(acc, 12)), du1_r);
        D_N0:   n0_r <= sat24(64'(x0_r) + rnd(acc, 13));
        D_N1:   n1_r <= sat24(64'(x1_r) + rnd(acc, 13));
        default: ;
      endcase
    end
    if ((state_r == S_DIVW0) && div_done) begin
      n0_r <= (det_r == '0) ? '0 : qsat(num0_r[ACC_W-1], quo);
    end
    if ((state_r == S_DIVW1) && div_done) begin
      n1_r <= (det_r == '0) ? '0 : qsat(num1_r[ACC_W-1], quo);
    end
    if (emit) begin
      out_data_r.out_value   <= sat16(rnd(acc, 16));
      out_data_r.out_channel <= 4'(j_r);
      out_data_r.out_last    <= (j_r == OUT_AW'(OUTPUT_WIDTH - 1));
    end
  end

  assign num_sel  = (state_r == S_DIV1) ? num1_r : num0_r;
  assign num_abs  = num_sel[ACC_W-1] ? -num_sel : num_sel;
  assign dividend = num_abs[DIV_NW-1:0] + DIV_NW'(det_r >> 1);

  osss_mac u_mac (
    .clk   (clk),
    .en    (mac_en),
    .first (mac_first),
    .neg   (mac_neg),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  osss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (det_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT_EMIT))
    else $error("output item raised outside the emit state");

  a_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !wb_en_r)
    else $error("writeback pending while idle");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_EMIT && out_valid_r && !out_ready) |=>
      (state_r == S_OUT_EMIT && $stable(j_r)))
    else $error("emit state left while the output register was full");

endmodule

`default_nettype wire

FILE: dv/tb_oscillator_state_space_scan.sv
`default_nettype none

module tb_oscillator_state_space_scan;
  import osss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  oscillator_state_space_scan i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the layer: weights, tables, sample buffer and state.
  logic signed [15:0] in_wt [BW_DEPTH];
  logic signed [15:0] out_wt [CW_DEPTH];
  logic signed [15:0] damp_tab [OSCILLATORS];
  logic signed [15:0] freq_tab [OSCILLATORS];
  logic signed [15:0] bias_tab [OUTPUT_WIDTH];
  logic signed [15:0] sample_buf [INPUT_WIDTH];
  longint osc_x [STATE_SIZE];
  logic heun_mode;
  logic [15:0] dt_q12;

  out_item_t expected_outputs[$];
  int fail_count;
  int items_sent;
  int steps_run;
  int outputs_seen;
  int idle_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  task automatic advance_oscillators();
    longint u [STATE_SIZE];
    longint acc, lam, om, x0, x1, n0, n1, dt;
    longint dl, dw, a, nn, r0, r1, det;
    longint du0, du1, ax0, ax1, ah0, ah1, k10, k11, xh0, xh1, k20, k21;
    dt = longint'(dt_q12);
    for (int j = 0; j < STATE_SIZE; j++) begin
      acc = 0;
      for (int i = 0; i < INPUT_WIDTH; i++)
        acc += longint'(in_wt[i * STATE_SIZE + j]) * longint'(sample_buf[i]);
      u[j] = clamp(round_shift(acc, 8), 24);
    end
    for (int k = 0; k < OSCILLATORS; k++) begin
      lam = damp_tab[k];
      om = freq_tab[k];
      x0 = osc_x[2 * k];
      x1 = osc_x[2 * k + 1];
      if (!heun_mode) begin
        dl = round_shift(dt * lam, 13);
        dw = round_shift(dt * om, 13);
        a = 4096 + dl;
        nn = 4096 - dl;
        r0 = clamp(round_shift(nn * x0 + dw * x1 + dt * u[2 * k], 12), 24);
        r1 = clamp(round_shift(-dw * x0 + nn * x1 + dt * u[2 * k + 1], 12), 24);
        det = a * a + dw * dw;
        if (det == 0) begin
          n0 = 0;
          n1 = 0;
        end else begin
          n0 = clamp(div_nearest((a * r0 + dw * r1) * 4096, det), 24);
          n1 = clamp(div_nearest((-dw * r0 + a * r1) * 4096, det), 24);
        end
      end else begin
        du0 = clamp(round_shift(dt * u[2 * k], 12), 24);
        du1 = clamp(round_shift(dt * u[2 * k + 1], 12), 24);
        ax0 = clamp(round_shift(-lam * x0 + om * x1, 12), 24);
        ax1 = clamp(round_shift(-om * x0 - lam * x1, 12), 24);
        k10 = clamp(ax0 + du0, 24);
        k11 = clamp(ax1 + du1, 24);
        xh0 = clamp(x0 + k10, 24);
        xh1 = clamp(x1 + k11, 24);
        ah0 = clamp(round_shift(-lam * xh0 + om * xh1, 12), 24);
        ah1 = clamp(round_shift(-om * xh0 - lam * xh1, 12), 24);
        k20 = clamp(ah0 + du0, 24);
        k21 = clamp(ah1 + du1, 24);
        n0 = clamp(x0 + round_shift(dt * (k10 + k20), 13), 24);
        n1 = clamp(x1 + round_shift(dt * (k11 + k21), 13), 24);
      end
      osc_x[2 * k] = n0;
      osc_x[2 * k + 1] = n1;
    end
  endtask

  task automatic predict_layer(in_item_t it);
    out_item_t res;
    longint acc;
    case (it.action)
      ACT_IN_W:
        if (it.row_index < INPUT_WIDTH)
          in_wt[it.row_index * STATE_SIZE + it.col_index] = it.word_value;
      ACT_OUT_W:
        if (it.col_index < OUTPUT_WIDTH)
          out_wt[it.row_index * OUTPUT_WIDTH + it.col_index] = it.word_value;
      ACT_DAMP: if (it.row_index < OSCILLATORS) damp_tab[it.row_index] = it.word_value;
      ACT_FREQ: if (it.row_index < OSCILLATORS) freq_tab[it.row_index] = it.word_value;
      ACT_BIAS: if (it.row_index < OUTPUT_WIDTH) bias_tab[it.row_index] = it.word_value;
      ACT_CLEAR: foreach (osc_x[i]) osc_x[i] = 0;
      ACT_SAMPLE: begin
        if (it.row_index < INPUT_WIDTH) sample_buf[it.row_index] = it.word_value;
        if (it.step_last) begin
          advance_oscillators();
          steps_run++;
          for (int j = 0; j < OUTPUT_WIDTH; j++) begin
            acc = longint'(bias_tab[j]) * 65536;
            for (int i = 0; i < STATE_SIZE; i++)
              acc += longint'(out_wt[i * OUTPUT_WIDTH + j]) * osc_x[i];
            res.out_value = 16'(clamp(round_shift(acc, 16), 16));
            res.out_channel = 4'(j);
            res.out_last = (j == OUTPUT_WIDTH - 1);
            expected_outputs.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_layer(it);
    items_sent++;
  endtask

  task automatic send_fields(action_t act, int row, int col, int word, bit last);
    in_item_t it;
    it.action = act;
    it.row_index = 4'(row);
    it.col_index = 4'(col);
    it.word_value = 16'(word);
    it.step_last = last;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_outputs.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MODE) heun_mode = value[0];
    else dt_q12 = 16'(value);
  endtask

  function automatic int random_word();
    if ($urandom_range(7) == 0) return int'($urandom_range(65535));
    return int'($urandom_range(4095)) - 2048;
  endfunction

  task automatic run_step(bit full);
    int n;
    n = full ? INPUT_WIDTH : int'($urandom_range(1, INPUT_WIDTH));
    for (int i = 0; i < n; i++)
      send_fields(ACT_SAMPLE, full ? i : int'($urandom_range(INPUT_WIDTH - 1)),
                  $urandom_range(15), random_word(), i == n - 1);
  endtask

  task automatic test_load_all();
    for (int r = 0; r < INPUT_WIDTH; r++)
      for (int c = 0; c < STATE_SIZE; c++)
        send_fields(ACT_IN_W, r, c, random_word(), $urandom_range(1));
    for (int r = 0; r < STATE_SIZE; r++)
      for (int c = 0; c < OUTPUT_WIDTH; c++)
        send_fields(ACT_OUT_W, r, c, random_word(), $urandom_range(1));
    for (int k = 0; k < OSCILLATORS; k++) begin
      send_fields(ACT_DAMP, k, $urandom_range(15), int'($urandom_range(1024)), 1'b0);
      send_fields(ACT_FREQ, k, $urandom_range(15), random_word(), 1'b0);
      send_fields(ACT_BIAS, k, $urandom_range(15), random_word(), 1'b1);
      send_fields(ACT_SAMPLE, k, $urandom_range(15), random_word(), 1'b0);
    end
  endtask

  task automatic test_directed();
    send_fields(ACT_SAMPLE, 0, 0, 32767, 1'b0);
    send_fields(ACT_SAMPLE, 7, 15, -32768, 1'b1);
    send_fields(ACT_IN_W, 15, 15, 1234, 1'b0);
    send_fields(ACT_OUT_W, 3, 12, -5, 1'b1);
    send_fields(ACT_DAMP, 9, 0, 77, 1'b0);
    send_fields(ACT_FREQ, 12, 0, 77, 1'b0);
    send_fields(ACT_BIAS, 8, 0, 77, 1'b0);
    send_fields(action_t'(3'd7), 5, 5, 999, 1'b1);
    send_fields(ACT_SAMPLE, 11, 3, 4000, 1'b1);
    send_fields(ACT_CLEAR, 0, 0, 0, 1'b1);
    send_fields(ACT_SAMPLE, 2, 0, 16'h7FFF, 1'b1);
    // A damping of -2.0 at dt 1.0 with zero frequency makes the pair singular.
    send_fields(ACT_DAMP, 0, 0, -8192, 1'b0);
    send_fields(ACT_FREQ, 0, 0, 0, 1'b0);
    send_fields(ACT_SAMPLE, 1, 0, 300, 1'b1);
    send_fields(ACT_BIAS, 7, 0, 32767, 1'b0);
    send_fields(ACT_BIAS, 6, 0, -32768, 1'b0);
    send_fields(ACT_SAMPLE, 4, 0, -1, 1'b1);
    send_fields(ACT_DAMP, 0, 0, 200, 1'b0);
    send_fields(ACT_FREQ, 0, 0, 3000, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_phase(bit mode, int dt, int count);
    int sent;
    write_reg(CFG_MODE, mode);
    write_reg(CFG_STEP, dt);
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0: begin
          send_fields(action_t'($urandom_range(4)), $urandom_range(15), $urandom_range(15),
                      random_word(), $urandom_range(1));
          sent++;
        end
        1: begin
          send_fields($urandom_range(1) ? ACT_CLEAR : action_t'(3'd7), $urandom_range(15),
                      $urandom_range(15), random_word(), $urandom_range(1));
        end
        2: begin
          send_fields(ACT_SAMPLE, $urandom_range(INPUT_WIDTH, 15), $urandom_range(15),
                      random_word(), 1'b1);
          sent++;
        end
        default: begin
          run_step($urandom_range(1));
          sent += 4;
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_quiet_stream();
    idle_pct = 0;
    write_reg(CFG_MODE, 1);
    for (int i = 0; i < 4; i++) run_step(1'b1);
    wait_idle();
    idle_pct = 30;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (idle_pct == 0) || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      outputs_seen++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output item: value %0d channel %0d",
               out_data.out_value, out_data.out_channel);
        fail_count++;
      end else begin
        exp_item = expected_outputs.pop_front();
        if (out_data.out_value !== exp_item.out_value) begin
          $error("out_value: expected %0d, actual %0d",
                 exp_item.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.out_channel !== exp_item.out_channel) begin
          $error("out_channel: expected %0d, actual %0d",
                 exp_item.out_channel, out_data.out_channel);
          fail_count++;
        end
        if (out_data.out_last !== exp_item.out_last) begin
          $error("out_last: expected %0d, actual %0d",
                 exp_item.out_last, out_data.out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    fail_count = 0;
    items_sent = 0;
    steps_run = 0;
    outputs_seen = 0;
    idle_pct = 30;
    heun_mode = 1'b0;
    dt_q12 = 16'd4096;
    foreach (osc_x[i]) osc_x[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_MODE, 0);
    write_reg(CFG_STEP, 4096);
    test_load_all();
    test_directed();
    test_random_phase(1'b0, 4096, 40);
    test_random_phase(1'b1, 512, 40);
    test_random_phase(1'b0, 65535, 30);
    test_random_phase(1'b1, 0, 20);
    test_random_phase(1'b0, 0, 20);
    test_random_phase(1'b1, 65535, 20);
    test_quiet_stream();
    test_random_phase(1'b0, int'($urandom_range(65535)), 30);

    wait_idle();
    $display("Sent %0d items covering %0d time steps in both update modes;", items_sent,
             steps_run);
    $display("checked %0d output items across step sizes from zero to maximum.",
             outputs_seen);
    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/osss_pkg.sv
rtl/osss_mac.sv
rtl/osss_div.sv
rtl/oscillator_state_space_scan.sv
dv/tb_oscillator_state_space_scan.sv
